// ----- design/ssvt_pkg.sv -----
// ---------------------------------------------------------------------------
// ssvt_pkg: shared types and constants for the sorted selector/value table
// Holds payload structs, status and command codes, and state encodings.
// ---------------------------------------------------------------------------
`default_nettype none
package ssvt_pkg;
   localparam int Capacity = 64;
   localparam int AddrW = $clog2(Capacity);
   localparam int CountW = $clog2(Capacity + 1);

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0, CMD_REPLACE = 2'd1, CMD_REMOVE = 2'd2, CMD_FIND = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_BAD_VALUE = 3'd1, ST_BAD_LOCATION = 3'd2,
      ST_UNDEF_KEY = 3'd3, ST_DUP_KEY = 3'd4, ST_FULL = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CSR_HEAP_START = 2'd0, CSR_ROM_BASE = 2'd1, CSR_ADDRESS_MASK = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] selector;
      logic [31:0] new_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        found;
      logic [6:0]  entry_index;
      logic [31:0] old_value;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH, S_SRCH_WAIT, S_HIT_RD, S_HIT_WAIT, S_DECIDE,
      S_SHIFT_RD, S_SHIFT_WAIT, S_SHIFT_WR, S_DONE
   } state_type;

   // memory port bundle between sequencer and store
   typedef struct packed {
      logic             rd_en;
      logic [AddrW-1:0] rd_addr;
      logic             wr_en;
      logic [AddrW-1:0] wr_addr;
      logic [31:0]      wr_key;
      logic [31:0]      wr_val;
   } mem_ctl_type;
endpackage
`default_nettype wire

// ----- design/ssvt_store.sv -----
// ---------------------------------------------------------------------------
// ssvt_store: key and value memories
// One write port and one registered read port, shared address per entry.
// ---------------------------------------------------------------------------
`default_nettype none
module ssvt_store (
   input  wire logic                 clock,
   input  wire ssvt_pkg::mem_ctl_type ctl,
   output logic [31:0]               rd_key,
   output logic [31:0]               rd_val
);
   logic [31:0] key_mem [ssvt_pkg::Capacity];
   logic [31:0] val_mem [ssvt_pkg::Capacity];

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         key_mem[ctl.wr_addr] <= ctl.wr_key;
         val_mem[ctl.wr_addr] <= ctl.wr_val;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_key <= key_mem[ctl.rd_addr];
         rd_val <= val_mem[ctl.rd_addr];
      end
   end
endmodule
`default_nettype wire

// ----- design/ssvt_seq.sv -----
// ---------------------------------------------------------------------------
// ssvt_seq: command sequencer
// Runs the lower-bound search, vets the value and shifts entries on insert
// or remove through the store's single read and write ports.
// ---------------------------------------------------------------------------
`default_nettype none
module ssvt_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ssvt_pkg::req_type     req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output ssvt_pkg::rsp_type          rsp_data,
   input  wire logic [31:0]           heap_start,
   input  wire logic [31:0]           rom_base,
   input  wire logic [31:0]           address_mask,
   output ssvt_pkg::mem_ctl_type      mem_ctl,
   input  wire logic [31:0]           rd_key,
   input  wire logic [31:0]           rd_val
);
   localparam int AW = ssvt_pkg::AddrW;
   localparam int CW = ssvt_pkg::CountW;

   ssvt_pkg::state_type state_ff, state_in;
   ssvt_pkg::req_type   req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [31:0]   skey_ff, skey_in, sval_ff, sval_in;
   logic          hit_ff, hit_in;
   logic [31:0]   old_ff, old_in;
   logic [2:0]    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ssvt_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0] mid;
   logic [31:0]   masked;
   logic          val_bad, loc_bad;
   logic          is_add;

   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign masked  = req_ff.new_value & address_mask;
   assign val_bad = (req_ff.new_value == 32'd0) || req_ff.new_value[0];
   assign loc_bad = (masked > heap_start) && (masked < rom_base);
   assign is_add  = (req_ff.cmd == ssvt_pkg::CMD_ADD);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssvt_pkg::S_IDLE:      if (req_valid) state_in = ssvt_pkg::S_SRCH;
         ssvt_pkg::S_SRCH:      state_in = (lo_ff < hi_ff) ? ssvt_pkg::S_SRCH_WAIT
                                                           : ssvt_pkg::S_HIT_RD;
         ssvt_pkg::S_SRCH_WAIT: state_in = ssvt_pkg::S_SRCH;
         ssvt_pkg::S_HIT_RD:    state_in = (lo_ff < count_ff) ? ssvt_pkg::S_HIT_WAIT
                                                              : ssvt_pkg::S_DECIDE;
         ssvt_pkg::S_HIT_WAIT:  state_in = ssvt_pkg::S_DECIDE;
         ssvt_pkg::S_DECIDE:    state_in = ssvt_pkg::S_DONE;
         ssvt_pkg::S_SHIFT_RD:  state_in = ssvt_pkg::S_SHIFT_WAIT;
         ssvt_pkg::S_SHIFT_WAIT: state_in = ssvt_pkg::S_SHIFT_WR;
         ssvt_pkg::S_SHIFT_WR:  state_in = ssvt_pkg::S_DONE;
         ssvt_pkg::S_DONE:      if (!rsp_valid_ff || !rsp_stall) state_in = ssvt_pkg::S_IDLE;
         default:               state_in = ssvt_pkg::S_IDLE;
      endcase
      // shifting loops back on itself until the pointer reaches its end
      if (state_ff == ssvt_pkg::S_DECIDE && status_in == ssvt_pkg::ST_OK &&
          (req_ff.cmd == ssvt_pkg::CMD_REMOVE || is_add)) begin
         state_in = ssvt_pkg::S_SHIFT_RD;
         if (is_add && ptr_in == lo_ff) state_in = ssvt_pkg::S_SHIFT_WR;
         if (!is_add && ptr_in + 1'b1 >= count_ff) state_in = ssvt_pkg::S_DONE;
      end
      if (state_ff == ssvt_pkg::S_SHIFT_WR) begin
         if (is_add && ptr_ff != lo_ff) begin
            state_in = (ptr_ff - 1'b1 == lo_ff) ? ssvt_pkg::S_SHIFT_WR
                                                : ssvt_pkg::S_SHIFT_RD;
         end
         if (!is_add && ptr_ff + 2'd2 < count_ff) state_in = ssvt_pkg::S_SHIFT_RD;
      end
   end

   // datapath and outputs
   always_comb begin
      req_in = req_ff;  count_in = count_ff;  lo_in = lo_ff;  hi_in = hi_ff;
      ptr_in = ptr_ff;  skey_in = skey_ff;    sval_in = sval_ff;
      hit_in = hit_ff;  old_in = old_ff;      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      mem_ctl = '0;
      req_stall = (state_ff != ssvt_pkg::S_IDLE);
      case (state_ff)
         ssvt_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;  lo_in = '0;  hi_in = count_ff;
               old_in = '0;        hit_in = 1'b0;
            end
         end
         ssvt_pkg::S_SRCH: begin
            mem_ctl.rd_en   = (lo_ff < hi_ff);
            mem_ctl.rd_addr = mid[AW-1:0];
            if (!(lo_ff < hi_ff)) begin
               mem_ctl.rd_en   = (lo_ff < count_ff);
               mem_ctl.rd_addr = lo_ff[AW-1:0];
            end
         end
         ssvt_pkg::S_SRCH_WAIT: begin
            if (rd_key < req_ff.selector) lo_in = mid + 1'b1;
            else hi_in = mid;
         end
         ssvt_pkg::S_HIT_WAIT: begin
            hit_in = (rd_key == req_ff.selector);
            sval_in = rd_val;
         end
         ssvt_pkg::S_DECIDE: begin
            status_in = ssvt_pkg::ST_OK;
            if (req_ff.cmd == ssvt_pkg::CMD_ADD || req_ff.cmd == ssvt_pkg::CMD_REPLACE) begin
               if (val_bad) status_in = ssvt_pkg::ST_BAD_VALUE;
               else if (loc_bad) status_in = ssvt_pkg::ST_BAD_LOCATION;
               else if (!is_add) begin
                  if (!hit_ff) status_in = ssvt_pkg::ST_UNDEF_KEY;
                  else begin
                     old_in = sval_ff;
                     mem_ctl.wr_en = 1'b1;  mem_ctl.wr_addr = lo_ff[AW-1:0];
                     mem_ctl.wr_key = req_ff.selector;
                     mem_ctl.wr_val = req_ff.new_value;
                  end
               end else if (hit_ff) status_in = ssvt_pkg::ST_DUP_KEY;
               else if (count_ff >= CW'(ssvt_pkg::Capacity)) status_in = ssvt_pkg::ST_FULL;
            end else begin
               if (!hit_ff) status_in = ssvt_pkg::ST_UNDEF_KEY;
               else old_in = sval_ff;
            end
            // insert walks down from count, remove walks up from the hit
            ptr_in = is_add ? count_ff : lo_ff;
            if (status_in == ssvt_pkg::ST_OK) begin
               if (is_add) count_in = count_ff + 1'b1;
               if (req_ff.cmd == ssvt_pkg::CMD_REMOVE) count_in = count_ff - 1'b1;
            end
            // count already moved; shift loops use the pre-command bound
            if (req_ff.cmd == ssvt_pkg::CMD_REMOVE) count_in = count_ff;
         end
         ssvt_pkg::S_SHIFT_RD: begin
            mem_ctl.rd_en = 1'b1;
            mem_ctl.rd_addr = is_add ? AW'(ptr_ff - 1'b1) : AW'(ptr_ff + 1'b1);
         end
         ssvt_pkg::S_SHIFT_WAIT: begin
            skey_in = rd_key;  sval_in = rd_val;
         end
         ssvt_pkg::S_SHIFT_WR: begin
            mem_ctl.wr_en = 1'b1;
            mem_ctl.wr_addr = ptr_ff[AW-1:0];
            if (is_add && ptr_ff == lo_ff) begin
               mem_ctl.wr_key = req_ff.selector;
               mem_ctl.wr_val = req_ff.new_value;
            end else begin
               mem_ctl.wr_key = skey_ff;
               mem_ctl.wr_val = sval_ff;
            end
            if (is_add) begin
               if (ptr_ff != lo_ff) ptr_in = ptr_ff - 1'b1;
            end else ptr_in = ptr_ff + 1'b1;
         end
         ssvt_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = status_ff;
               rsp_in.found = hit_ff;
               rsp_in.entry_index = 7'(lo_ff);
               rsp_in.old_value = old_ff;
               if (req_ff.cmd == ssvt_pkg::CMD_REMOVE && status_ff == ssvt_pkg::ST_OK) begin
                  rsp_in.entry_count = 7'(count_ff - 1'b1);
                  count_in = count_ff - 1'b1;
               end else rsp_in.entry_count = 7'(count_ff);
            end
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssvt_pkg::S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;  lo_ff <= lo_in;  hi_ff <= hi_in;  ptr_ff <= ptr_in;
      skey_ff <= skey_in;  sval_ff <= sval_in;  hit_ff <= hit_in;
      old_ff <= old_in;  status_ff <= status_in;  rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

// ----- design/sorted_selector_value_table_core.sv -----
// Sorted selector/value table. Keeps up to 64 key/value pairs sorted by key
// in a memory with one write port and one registered read port. Every command
// runs a lower-bound binary search, each probe a read state and a wait state
// (up to seven probes); add and replace then vet the value. Add shifts the
// entries at and above the insertion point up and remove shifts those above
// the hit down, one at a time, each entry through a read, a wait and a write
// state. One command is in flight at a time; a finished beat waits in an
// output register.
// ---------------------------------------------------------------------------
// sorted_selector_value_table_core: top level
// Configuration registers, store and command sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
module sorted_selector_value_table_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ssvt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ssvt_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_wdata
);
   logic [31:0] heap_start_ff, rom_base_ff, address_mask_ff;
   ssvt_pkg::mem_ctl_type mem_ctl;
   logic [31:0] rd_key, rd_val;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_start_ff <= '0;
         rom_base_ff <= '0;
         address_mask_ff <= '1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ssvt_pkg::CSR_HEAP_START:   heap_start_ff <= csr_wdata;
            ssvt_pkg::CSR_ROM_BASE:     rom_base_ff <= csr_wdata;
            ssvt_pkg::CSR_ADDRESS_MASK: address_mask_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ssvt_store u_store (.clock(clock), .ctl(mem_ctl), .rd_key(rd_key), .rd_val(rd_val));

   ssvt_seq u_seq (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .heap_start(heap_start_ff), .rom_base(rom_base_ff),
      .address_mask(address_mask_ff),
      .mem_ctl(mem_ctl), .rd_key(rd_key), .rd_val(rd_val)
   );
endmodule
`default_nettype wire

// ----- design/ssvt_checker.sv -----
// ---------------------------------------------------------------------------
// ssvt_checker: port-level checks
// Watches the handshake and result fields of the table core.
// ---------------------------------------------------------------------------
`default_nettype none
module ssvt_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire ssvt_pkg::rsp_type rsp_data
);
   // a stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed under stall");

   // count never exceeds capacity
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= 7'd64)
      else $error("entry count out of range");

   // an undefined key is never reported as found
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ssvt_pkg::ST_UNDEF_KEY |-> !rsp_data.found)
      else $error("undefined key reported as found");

   // an accepted request stalls the input next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");
endmodule

bind sorted_selector_value_table_core ssvt_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
`default_nettype wire

// ----- test/sorted_selector_value_table_core_test.sv -----
// ---------------------------------------------------------------------------
// sorted_selector_value_table_core_test: self-checking bench for the table
// Drives add/replace/remove/find beats, predicts each response from a local
// sorted table model, and compares every response beat field by field.
// ---------------------------------------------------------------------------
`default_nettype none
module sorted_selector_value_table_core_test;
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   ssvt_pkg::req_type    req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   ssvt_pkg::rsp_type    rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [1:0]           csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   sorted_selector_value_table_core uut (.*);

   always #5 clock = ~clock;

   // shadow of the table and registers
   logic [31:0] shadow_keys [0:ssvt_pkg::Capacity-1];
   logic [31:0] shadow_vals [0:ssvt_pkg::Capacity-1];
   int          shadow_count;
   logic [31:0] heap_lo, rom_hi, addr_mask;

   ssvt_pkg::rsp_type pending_rsp [$];
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   // compute the expected response and update the shadow table
   function automatic ssvt_pkg::rsp_type predict_table(ssvt_pkg::req_type r);
      ssvt_pkg::rsp_type o;
      int          lo, hi, mid, i;
      logic        hit;
      logic [31:0] masked;
      lo = 0;
      hi = shadow_count;
      while (lo < hi) begin
         mid = lo + ((hi - lo) >> 1);
         if (shadow_keys[mid] < r.selector) lo = mid + 1;
         else hi = mid;
      end
      hit = (lo < shadow_count) && (shadow_keys[lo] == r.selector);
      o = '0;
      o.status = ssvt_pkg::ST_OK;
      masked = r.new_value & addr_mask;
      if (r.cmd == ssvt_pkg::CMD_ADD || r.cmd == ssvt_pkg::CMD_REPLACE) begin
         if (r.new_value == 0 || r.new_value[0]) o.status = ssvt_pkg::ST_BAD_VALUE;
         else if (masked > heap_lo && masked < rom_hi) o.status = ssvt_pkg::ST_BAD_LOCATION;
         else if (r.cmd == ssvt_pkg::CMD_REPLACE) begin
            if (!hit) o.status = ssvt_pkg::ST_UNDEF_KEY;
            else begin
               o.old_value = shadow_vals[lo];
               shadow_vals[lo] = r.new_value;
            end
         end else if (hit) o.status = ssvt_pkg::ST_DUP_KEY;
         else if (shadow_count >= ssvt_pkg::Capacity) o.status = ssvt_pkg::ST_FULL;
         else begin
            for (i = shadow_count; i > lo; i--) begin
               shadow_keys[i] = shadow_keys[i-1];
               shadow_vals[i] = shadow_vals[i-1];
            end
            shadow_keys[lo] = r.selector;
            shadow_vals[lo] = r.new_value;
            shadow_count++;
         end
      end else if (r.cmd == ssvt_pkg::CMD_REMOVE) begin
         if (!hit) o.status = ssvt_pkg::ST_UNDEF_KEY;
         else begin
            o.old_value = shadow_vals[lo];
            for (i = lo; i + 1 < shadow_count; i++) begin
               shadow_keys[i] = shadow_keys[i+1];
               shadow_vals[i] = shadow_vals[i+1];
            end
            shadow_count--;
         end
      end else begin
         if (!hit) o.status = ssvt_pkg::ST_UNDEF_KEY;
         else o.old_value = shadow_vals[lo];
      end
      o.found = hit;
      o.entry_index = lo[6:0];
      o.entry_count = shadow_count[6:0];
      return o;
   endfunction

   // send one request beat, with optional idle cycles before it
   task automatic send_request(logic [1:0] cmd, logic [31:0] sel, logic [31:0] val);
      ssvt_pkg::req_type r;
      r.cmd = cmd;
      r.selector = sel;
      r.new_value = val;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      pending_rsp.push_back(predict_table(r));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic write_csr(ssvt_pkg::csr_index_type idx, logic [31:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         ssvt_pkg::CSR_HEAP_START: heap_lo = v;
         ssvt_pkg::CSR_ROM_BASE: rom_hi = v;
         default: addr_mask = v;
      endcase
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // response checker
   always @(posedge clock) begin
      ssvt_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response beat %h", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status || rsp_data.found !== want.found ||
                rsp_data.entry_index !== want.entry_index ||
                rsp_data.old_value !== want.old_value ||
                rsp_data.entry_count !== want.entry_count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %h actual %h", want, rsp_data);
            end
         end
      end
   end

   // random even value, mostly legal
   function automatic logic [31:0] rand_value();
      logic [31:0] v;
      v = $urandom() & 32'hFFFF_FFFE;
      if (v == 0) v = 2;
      case ($urandom_range(19))
         0: v = 0;
         1: v = v | 1;
         default: ;
      endcase
      return v;
   endfunction

   // key from a small pool so hits are common, or a fully random one
   function automatic logic [31:0] rand_key(int pool);
      if ($urandom_range(9) == 0) return $urandom();
      return $urandom_range(pool) * 32'h0101_0101;
   endfunction

   task automatic test_directed();
      send_request(ssvt_pkg::CMD_FIND, 32'h0, 32'h0);
      send_request(ssvt_pkg::CMD_REMOVE, 32'h5, 32'h0);
      send_request(ssvt_pkg::CMD_REPLACE, 32'h5, 32'h4);
      send_request(ssvt_pkg::CMD_ADD, 32'h0, 32'h0);
      send_request(ssvt_pkg::CMD_ADD, 32'h0, 32'h3);
      send_request(ssvt_pkg::CMD_ADD, 32'h0, 32'hFFFF_FFFE);
      send_request(ssvt_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h2);
      send_request(ssvt_pkg::CMD_ADD, 32'h8000_0000, 32'h5555_5554);
      send_request(ssvt_pkg::CMD_ADD, 32'h8000_0000, 32'h8);
      send_request(ssvt_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(ssvt_pkg::CMD_REPLACE, 32'h8000_0000, 32'hAAAA_AAAA);
      send_request(ssvt_pkg::CMD_REPLACE, 32'h8000_0000, 32'hAAAA_AAAB);
      send_request(ssvt_pkg::CMD_REMOVE, 32'h0, 32'hFFFF_FFFF);
      send_request(ssvt_pkg::CMD_FIND, 32'h0, 32'h0);
      send_request(ssvt_pkg::CMD_FIND, 32'h8000_0000, 32'h0);
      wait_drained();
      write_csr(ssvt_pkg::CSR_HEAP_START, 32'h1000);
      write_csr(ssvt_pkg::CSR_ROM_BASE, 32'h2000);
      write_csr(ssvt_pkg::CSR_ADDRESS_MASK, 32'h0000_FFFF);
      send_request(ssvt_pkg::CMD_ADD, 32'h10, 32'hABCD_1800);
      send_request(ssvt_pkg::CMD_ADD, 32'h10, 32'hABCD_1000);
      send_request(ssvt_pkg::CMD_ADD, 32'h10, 32'hABCD_2000);
      send_request(ssvt_pkg::CMD_REPLACE, 32'h10, 32'h0000_1002);
      send_request(ssvt_pkg::CMD_REPLACE, 32'h10, 32'h0000_0FFE);
      wait_drained();
   endtask

   // fill until full, then probe the full and duplicate cases and remove entries again
   task automatic test_full_table();
      int i;
      write_csr(ssvt_pkg::CSR_HEAP_START, 32'h0);
      write_csr(ssvt_pkg::CSR_ROM_BASE, 32'h0);
      write_csr(ssvt_pkg::CSR_ADDRESS_MASK, 32'hFFFF_FFFF);
      for (i = 0; i < ssvt_pkg::Capacity + 2; i++)
         send_request(ssvt_pkg::CMD_ADD, $urandom(), rand_value() & 32'hFFFF_FFFE | 32'h2);
      send_request(ssvt_pkg::CMD_ADD, shadow_keys[0], 32'h2);
      send_request(ssvt_pkg::CMD_ADD, shadow_keys[ssvt_pkg::Capacity-1], 32'h2);
      send_request(ssvt_pkg::CMD_FIND, shadow_keys[ssvt_pkg::Capacity-1], 32'h0);
      for (i = 0; i < ssvt_pkg::Capacity + 2; i++)
         send_request(ssvt_pkg::CMD_REMOVE, shadow_keys[$urandom_range(shadow_count > 0 ?
            shadow_count - 1 : 0)], $urandom());
      wait_drained();
   endtask

   task automatic test_random_phase(int n, int idle, int stall, int pool);
      int       i;
      int       c;
      send_idle_pct = idle;
      stall_pct = stall;
      for (i = 0; i < n; i++) begin
         c = $urandom_range(9);
         if (c < 4) send_request(ssvt_pkg::CMD_ADD, rand_key(pool), rand_value());
         else if (c < 6) send_request(ssvt_pkg::CMD_REPLACE, rand_key(pool), rand_value());
         else if (c < 8) send_request(ssvt_pkg::CMD_REMOVE, rand_key(pool), $urandom());
         else send_request(ssvt_pkg::CMD_FIND, rand_key(pool), $urandom());
      end
      wait_drained();
   endtask

   initial begin
      heap_lo = 32'h0;
      rom_hi = 32'h0;
      addr_mask = 32'hFFFF_FFFF;
      shadow_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_random_phase(400, 0, 0, 90);
      write_csr(ssvt_pkg::CSR_HEAP_START, 32'h4000_0000);
      write_csr(ssvt_pkg::CSR_ROM_BASE, 32'hC000_0000);
      test_random_phase(400, 55, 0, 70);
      write_csr(ssvt_pkg::CSR_ADDRESS_MASK, 32'h3FFF_FFFF);
      write_csr(ssvt_pkg::CSR_HEAP_START, 32'h0);
      write_csr(ssvt_pkg::CSR_ROM_BASE, 32'hFFFF_FFFF);
      test_random_phase(350, 0, 55, 60);
      write_csr(ssvt_pkg::CSR_ADDRESS_MASK, 32'h0);
      write_csr(ssvt_pkg::CSR_ROM_BASE, 32'h1000_0000);
      test_random_phase(350, 16, 16, 120);
      write_csr(ssvt_pkg::CSR_ADDRESS_MASK, 32'hFFFF_FFFF);
      write_csr(ssvt_pkg::CSR_HEAP_START, 32'hFFFF_FFFF);
      write_csr(ssvt_pkg::CSR_ROM_BASE, 32'h0);
      test_random_phase(200, 0, 0, 40);
      if (mismatch_count == 0 && pending_rsp.size() == 0)
         $display("sorted_selector_value_table_core verification clean");
      else
         $display("sorted_selector_value_table_core verification failed");
      $finish;
   end

   // run time limit
   initial begin
      #20000000;
      $display("sorted_selector_value_table_core verification failed");
      $finish;
   end
endmodule
`default_nettype wire

// ----- sorted_selector_value_table_core.f -----
design/ssvt_pkg.sv
design/ssvt_store.sv
design/ssvt_seq.sv
design/sorted_selector_value_table_core.sv
design/ssvt_checker.sv
test/sorted_selector_value_table_core_test.sv
